// ===== hw/rtl/lbs_pkg.sv =====
package lbs_pkg;

  localparam int NUM_BONES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WEIGHT_BITS   = 16;
  localparam int SUM_W         = 66;
  localparam int WPROD_W       = 50;

  typedef enum logic [2:0] {
    OP_LOAD_POS  = 3'd0,
    OP_LOAD_NRM  = 3'd1,
    OP_VERTEX    = 3'd2,
    OP_NORMAL    = 3'd3,
    OP_PASS      = 3'd4
  } opcode_t;

  typedef struct packed {
    logic mul_en;
    logic trn_sel;
    logic add_en;
    logic sum_clr;
    logic wmul_en;
    logic acc_en;
    logic acc_clr;
  } dp_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(signed'(32'sh7fffffff))) begin
      r = 32'sh7fffffff;
    end else if (v < SUM_W'(signed'(32'sh80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/linear_blend_skinning.sv =====
// channel | dir | tdata (low bit up)                                   | tuser     | tlast
// in_     | in  | bone, row, src_x, src_y, src_z, weight, zero fill    | opcode    | last_term
// out_    | out | out_x, out_y, out_z                                  | is_normal | -
// loads write the table as they are accepted, pass-through goes to S_EMIT plus output wait
// a vertex term takes 4 table row reads, each through S_RD, S_MUL and S_ADD, then S_WMUL
// and S_ACC; a normal term 3 rows; the single table port and shared row multiplier lanes
// set this order; reset clears control and accumulators; tables are undefined until loaded
// input stalls while a result waits in the output register and a new one is due
module linear_blend_skinning #(
  parameter int NUM_BONES = lbs_pkg::NUM_BONES_DEF,
  parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // bone, row, src_x, src_y, src_z, weight
  input  logic [2:0]   in_tuser,  // opcode
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata, // out_x, out_y, out_z
  output logic         out_tuser  // is_normal
);
  import lbs_pkg::*;

  localparam int DEPTH = NUM_BONES * 8;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ADD, S_WMUL, S_ACC, S_EMIT
  } state_t;

  state_t      state_r;
  logic [5:0]  bone_r;
  logic [1:0]  row_r;
  logic        nrm_r;
  logic        last_r;
  logic        pass_r;
  logic [95:0] src_r;
  logic [16:0] weight_r;
  logic        out_tvalid_r;
  logic [95:0] out_tdata_r;
  logic        out_tuser_r;

  logic        acc_in;
  logic [5:0]  in_bone;
  logic [1:0]  in_row;
  logic        bone_ok;
  logic        ram_we;
  logic        ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [95:0] ram_rdata;
  logic [95:0] result;
  dp_ctl_t     ctl;
  logic        out_free;

  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign in_bone   = in_tdata[5:0];
  assign in_row    = in_tdata[7:6];
  assign bone_ok   = 32'(in_bone) < NUM_BONES;
  assign out_free  = !out_tvalid_r || out_tready;

  assign ram_we = acc_in && bone_ok &&
                  ((in_tuser == OP_LOAD_POS) ||
                   ((in_tuser == OP_LOAD_NRM) && (in_row != 2'd3)));
  assign ram_waddr = AW'({in_bone, in_tuser == OP_LOAD_NRM, in_row});
  assign ram_re    = (state_r == S_RD);
  assign ram_raddr = AW'({bone_r, nrm_r, row_r});

  lbs_ram #(.W(96), .D(DEPTH)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata[103:8]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ctl         = '0;
    ctl.sum_clr = acc_in;
    ctl.mul_en  = (state_r == S_MUL);
    ctl.trn_sel = (row_r == 2'd3);
    ctl.add_en  = (state_r == S_ADD);
    ctl.wmul_en = (state_r == S_WMUL);
    ctl.acc_en  = (state_r == S_ACC);
    ctl.acc_clr = !rst_n || ((state_r == S_EMIT) && out_free && !pass_r);
  end

  logic [31:0] src_sel;
  always_comb begin
    case (row_r)
      2'd0:    src_sel = src_r[31:0];
      2'd1:    src_sel = src_r[63:32];
      default: src_sel = src_r[95:64];
    endcase
  end

  lbs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .src_sel  (src_sel),
    .row_data (ram_rdata),
    .weight   (weight_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      row_r        <= '0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            bone_r   <= in_bone;
            src_r    <= in_tdata[103:8];
            weight_r <= in_tdata[120:104];
            last_r   <= in_tlast;
            nrm_r    <= (in_tuser == OP_NORMAL);
            pass_r   <= (in_tuser == OP_PASS);
            row_r    <= '0;
            case (in_tuser)
              OP_PASS: state_r <= S_EMIT;
              OP_VERTEX, OP_NORMAL: begin
                if (bone_ok) begin
                  state_r <= S_RD;
                end else if (in_tlast) begin
                  state_r <= S_EMIT;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD:   state_r <= S_MUL;
        S_MUL:  state_r <= S_ADD;
        S_ADD: begin
          if (row_r == (nrm_r ? 2'd2 : 2'd3)) begin
            state_r <= S_WMUL;
          end else begin
            row_r   <= row_r + 2'd1;
            state_r <= S_RD;
          end
        end
        S_WMUL: state_r <= S_ACC;
        S_ACC:  state_r <= last_r ? S_EMIT : S_IDLE;
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= pass_r ? src_r : result;
            out_tuser_r  <= nrm_r && !pass_r;
            state_r      <= S_IDLE;
          end else if (out_tvalid_r && out_tready) begin
            out_tvalid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_pass_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_PASS) |=> (state_r == S_EMIT))
    else $error("pass-through did not go to emit");
  a_nrm_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && nrm_r) |-> (row_r != 2'd3))
    else $error("normal term read translation row");
  a_clr_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.acc_clr && ctl.acc_en))
    else $error("accumulator clear and add together");
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_tvalid)
    else $error("emit without output transaction");
`endif

endmodule

// ===== hw/rtl/lbs_ram.sv =====
module lbs_ram #(
  parameter int W = 96,
  parameter int D = 512
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lbs_dp.sv =====
module lbs_dp #(
  parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  lbs_pkg::dp_ctl_t  ctl,
  input  logic [31:0]       src_sel,
  input  logic [95:0]       row_data,
  input  logic [16:0]       weight,
  output logic [95:0]       result
);
  import lbs_pkg::*;

  logic signed [63:0]         prod_r  [3];
  logic signed [SUM_W-1:0]    sum_r   [3];
  logic signed [WPROD_W-1:0]  wprod_r [3];
  logic signed [63:0]         acc_r   [3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (ctl.mul_en) begin
        if (ctl.trn_sel) begin
          prod_r[j] <= 64'(signed'(row_data[j*32 +: 32])) <<< FRAC_BITS;
        end else begin
          prod_r[j] <= 64'(signed'(src_sel)) * 64'(signed'(row_data[j*32 +: 32]));
        end
      end
      if (ctl.sum_clr) begin
        sum_r[j] <= '0;
      end else if (ctl.add_en) begin
        sum_r[j] <= sum_r[j] + SUM_W'(prod_r[j] >>> FRAC_BITS);
      end
      if (ctl.wmul_en) begin
        wprod_r[j] <= WPROD_W'(sat32(sum_r[j])) * WPROD_W'(signed'({1'b0, weight}));
      end
    end
  end

  logic signed [64:0] acc_sum [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_sum[j] = 65'(acc_r[j]) + 65'(wprod_r[j]);
      result[j*32 +: 32] = sat32(SUM_W'(acc_r[j] >>> WEIGHT_BITS));
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      if (ctl.acc_clr) begin
        acc_r[j] <= '0;
      end else if (ctl.acc_en) begin
        if (acc_sum[j][64] != acc_sum[j][63]) begin
          acc_r[j] <= acc_sum[j][64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        end else begin
          acc_r[j] <= acc_sum[j][63:0];
        end
      end
    end
  end

endmodule
